/* src/acl_pkg.sv */
package acl_pkg;

  localparam int ENTRIES         = 8;
  localparam int WORDS_PER_BLOCK = 4;
  localparam int ADDR_BITS       = 16;
  localparam int AGE_BITS        = 8;

  localparam int IN_ADDR_BITS = 16;
  localparam int OUT_TAG_BITS = 14;
  localparam int WAY_BITS     = 3;
  localparam int CNT_BITS     = 32;

  localparam int OFFSET_BITS = $clog2(WORDS_PER_BLOCK);
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS;
  localparam int IDX_BITS    = $clog2(ENTRIES);
  localparam int FILL_BITS   = $clog2(ENTRIES + 1);

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } acl_cmd_t;

endpackage

/* src/acl_ctrl.sv */
module acl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output acl_pkg::acl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.lookup = (state_r == S_LOOKUP);
    cmd.commit = (state_r == S_UPDATE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* src/acl_dp.sv */
module acl_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  acl_pkg::acl_cmd_t                   cmd,
  input  logic [acl_pkg::IN_ADDR_BITS-1:0]    in_address,
  output logic                                out_hit,
  output logic [acl_pkg::WAY_BITS-1:0]        out_way,
  output logic                                out_filled_empty,
  output logic                                out_evicted,
  output logic [acl_pkg::OUT_TAG_BITS-1:0]    out_evicted_tag,
  output logic [acl_pkg::OUT_TAG_BITS-1:0]    out_new_tag,
  output logic [acl_pkg::CNT_BITS-1:0]        out_hit_count,
  output logic [acl_pkg::CNT_BITS-1:0]        out_miss_count
);

  logic [acl_pkg::TAG_BITS-1:0]  tag_r;
  logic [acl_pkg::TAG_BITS-1:0]  tag_store_r [acl_pkg::ENTRIES];
  logic [acl_pkg::ENTRIES-1:0]   valid_r;
  logic [acl_pkg::AGE_BITS-1:0]  age_r [acl_pkg::ENTRIES];
  logic [acl_pkg::FILL_BITS-1:0] fill_ptr_r;
  logic [acl_pkg::CNT_BITS-1:0]  hits_r;
  logic [acl_pkg::CNT_BITS-1:0]  misses_r;

  logic                          hit_r;
  logic [acl_pkg::IDX_BITS-1:0]  hit_idx_r;
  logic [acl_pkg::IDX_BITS-1:0]  vict_idx_r;

  logic                          hit_nxt;
  logic [acl_pkg::IDX_BITS-1:0]  hit_idx_nxt;
  logic [acl_pkg::IDX_BITS-1:0]  vict_idx_nxt;

  logic                          full;
  logic [acl_pkg::IDX_BITS-1:0]  sel;
  logic                          do_fill;
  logic                          do_replace;
  logic [acl_pkg::CNT_BITS-1:0]  hits_nxt;
  logic [acl_pkg::CNT_BITS-1:0]  misses_nxt;
  logic [acl_pkg::ADDR_BITS-1:0] addr;

  logic                          out_hit_r;
  logic [acl_pkg::WAY_BITS-1:0]  out_way_r;
  logic                          out_filled_r;
  logic                          out_evicted_r;
  logic [acl_pkg::OUT_TAG_BITS-1:0] out_evicted_tag_r;
  logic [acl_pkg::OUT_TAG_BITS-1:0] out_new_tag_r;
  logic [acl_pkg::CNT_BITS-1:0]  out_hit_count_r;
  logic [acl_pkg::CNT_BITS-1:0]  out_miss_count_r;

  assign addr = in_address[acl_pkg::ADDR_BITS-1:0];

  // Parallel tag compare with lowest-index priority, and the oldest-entry search.
  always_comb begin
    hit_nxt      = 1'b0;
    hit_idx_nxt  = '0;
    vict_idx_nxt = '0;
    for (int i = acl_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_store_r[i] == tag_r)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = acl_pkg::IDX_BITS'(i);
      end
    end
    for (int i = 1; i < acl_pkg::ENTRIES; i++) begin
      if (age_r[i] > age_r[vict_idx_nxt]) begin
        vict_idx_nxt = acl_pkg::IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    full       = (fill_ptr_r == acl_pkg::FILL_BITS'(acl_pkg::ENTRIES));
    do_fill    = !hit_r && !full;
    do_replace = !hit_r && full;
    priority if (hit_r) begin
      sel = hit_idx_r;
    end else if (!full) begin
      sel = fill_ptr_r[acl_pkg::IDX_BITS-1:0];
    end else begin
      sel = vict_idx_r;
    end
    hits_nxt   = (hit_r && (hits_r != acl_pkg::CNT_MAX)) ? hits_r + 1'b1 : hits_r;
    misses_nxt = (!hit_r && (misses_r != acl_pkg::CNT_MAX)) ? misses_r + 1'b1 : misses_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_r <= acl_pkg::TAG_BITS'(addr >> acl_pkg::OFFSET_BITS);
    end
    if (cmd.lookup) begin
      hit_r      <= hit_nxt;
      hit_idx_r  <= hit_idx_nxt;
      vict_idx_r <= vict_idx_nxt;
    end
    if (cmd.commit) begin
      if (!hit_r) begin
        tag_store_r[sel] <= tag_r;
      end
      out_hit_r         <= hit_r;
      out_way_r         <= acl_pkg::WAY_BITS'(sel);
      out_filled_r      <= do_fill;
      out_evicted_r     <= do_replace;
      out_evicted_tag_r <= do_replace ?
                           acl_pkg::OUT_TAG_BITS'(tag_store_r[sel]) : '0;
      out_new_tag_r     <= acl_pkg::OUT_TAG_BITS'(tag_r);
      out_hit_count_r   <= hits_nxt;
      out_miss_count_r  <= misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_ptr_r <= '0;
      hits_r     <= '0;
      misses_r   <= '0;
      for (int i = 0; i < acl_pkg::ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      hits_r       <= hits_nxt;
      misses_r     <= misses_nxt;
      valid_r[sel] <= 1'b1;
      if (do_fill) begin
        fill_ptr_r <= fill_ptr_r + 1'b1;
      end
      for (int i = 0; i < acl_pkg::ENTRIES; i++) begin
        if (acl_pkg::IDX_BITS'(i) == sel) begin
          age_r[i] <= '0;
        end else if (valid_r[i] && (age_r[i] != acl_pkg::AGE_MAX)) begin
          age_r[i] <= age_r[i] + 1'b1;
        end
      end
    end
  end

  assign out_hit          = out_hit_r;
  assign out_way          = out_way_r;
  assign out_filled_empty = out_filled_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_tag  = out_evicted_tag_r;
  assign out_new_tag      = out_new_tag_r;
  assign out_hit_count    = out_hit_count_r;
  assign out_miss_count   = out_miss_count_r;

endmodule

/* src/assoc_cache_lru_lookup.sv */
// A request is accepted in the idle step, its tag is compared in the lookup step and its result is
// registered on the outputs in the update step; the update waits while a previous result is still
// held on the output, and no new request is accepted until the update of the last one is done.
// Reset: synchronous, active low; clears the valid bits, ages, fill pointer, hit and miss totals
// and the controller. The tag store is not reset and is read only through valid entries.
module assoc_cache_lru_lookup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [acl_pkg::IN_ADDR_BITS-1:0] in_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [acl_pkg::WAY_BITS-1:0]     out_way,
  output logic                             out_filled_empty,
  output logic                             out_evicted,
  output logic [acl_pkg::OUT_TAG_BITS-1:0] out_evicted_tag,
  output logic [acl_pkg::OUT_TAG_BITS-1:0] out_new_tag,
  output logic [acl_pkg::CNT_BITS-1:0]     out_hit_count,
  output logic [acl_pkg::CNT_BITS-1:0]     out_miss_count
);

  acl_pkg::acl_cmd_t cmd;

  acl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  acl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_address       (in_address),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_filled_empty (out_filled_empty),
    .out_evicted      (out_evicted),
    .out_evicted_tag  (out_evicted_tag),
    .out_new_tag      (out_new_tag),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count)
  );

endmodule

/* tb/lru_lookup_checker.sv */
module lru_lookup_checker
  import acl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [IN_ADDR_BITS-1:0] in_address,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_hit,
  input  logic [WAY_BITS-1:0]     out_way,
  input  logic                    out_filled_empty,
  input  logic                    out_evicted,
  input  logic [OUT_TAG_BITS-1:0] out_evicted_tag,
  input  logic [OUT_TAG_BITS-1:0] out_new_tag,
  input  logic [CNT_BITS-1:0]     out_hit_count,
  input  logic [CNT_BITS-1:0]     out_miss_count,
  output int                      fail_count,
  output int                      pending,
  output int                      results_seen,
  output int                      hits_seen,
  output int                      fills_seen,
  output int                      evicts_seen
);

  typedef struct packed {
    logic                    hit;
    logic [WAY_BITS-1:0]     way;
    logic                    filled_empty;
    logic                    evicted;
    logic [OUT_TAG_BITS-1:0] evicted_tag;
    logic [OUT_TAG_BITS-1:0] new_tag;
    logic [CNT_BITS-1:0]     hit_count;
    logic [CNT_BITS-1:0]     miss_count;
  } lookup_result_t;

  logic [TAG_BITS-1:0] line_tag   [ENTRIES];
  logic                line_valid [ENTRIES];
  logic [AGE_BITS-1:0] line_age   [ENTRIES];
  int                  fill_ptr;
  logic [CNT_BITS-1:0] hits_total;
  logic [CNT_BITS-1:0] misses_total;

  lookup_result_t expected_q[$];
  lookup_result_t want;

  function automatic void age_line(input int idx);
    if (line_age[idx] != AGE_MAX) begin
      line_age[idx] = line_age[idx] + 1'b1;
    end
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [IN_ADDR_BITS-1:0] req_addr);
    logic [ADDR_BITS-1:0] word_addr;
    logic [TAG_BITS-1:0]  req_tag;
    lookup_result_t       r;
    int                   sel;
    bit                   found;
    word_addr = req_addr[ADDR_BITS-1:0];
    req_tag   = TAG_BITS'(word_addr / WORDS_PER_BLOCK);
    r         = '0;
    sel       = 0;
    found     = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && line_valid[i] && line_tag[i] == req_tag) begin
        sel   = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (hits_total != CNT_MAX) hits_total = hits_total + 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != sel && line_valid[i]) age_line(i);
      end
      line_age[sel] = '0;
    end else begin
      if (misses_total != CNT_MAX) misses_total = misses_total + 1'b1;
      if (fill_ptr < ENTRIES) begin
        sel            = fill_ptr;
        r.filled_empty = 1'b1;
        for (int i = 0; i < sel; i++) age_line(i);
        fill_ptr++;
      end else begin
        // The oldest line goes; a strict compare keeps the lowest index on ties.
        sel = 0;
        for (int i = 1; i < ENTRIES; i++) begin
          if (line_age[i] > line_age[sel]) sel = i;
        end
        r.evicted     = 1'b1;
        r.evicted_tag = OUT_TAG_BITS'(line_tag[sel]);
        for (int i = 0; i < ENTRIES; i++) begin
          if (i != sel) age_line(i);
        end
      end
      line_tag[sel]   = req_tag;
      line_valid[sel] = 1'b1;
      line_age[sel]   = '0;
    end
    r.hit        = found;
    r.way        = WAY_BITS'(sel);
    r.new_tag    = OUT_TAG_BITS'(req_tag);
    r.hit_count  = hits_total;
    r.miss_count = misses_total;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_BITS-1:0] exp_v,
                                      input logic [CNT_BITS-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_age[i]   = '0;
      end
      fill_ptr     = 0;
      hits_total   = '0;
      misses_total = '0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_lookup(in_address));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("hit", CNT_BITS'(want.hit), CNT_BITS'(out_hit));
          check_field("way", CNT_BITS'(want.way), CNT_BITS'(out_way));
          check_field("filled_empty", CNT_BITS'(want.filled_empty),
                      CNT_BITS'(out_filled_empty));
          check_field("evicted", CNT_BITS'(want.evicted), CNT_BITS'(out_evicted));
          check_field("evicted_tag", CNT_BITS'(want.evicted_tag),
                      CNT_BITS'(out_evicted_tag));
          check_field("new_tag", CNT_BITS'(want.new_tag), CNT_BITS'(out_new_tag));
          check_field("hit_count", want.hit_count, out_hit_count);
          check_field("miss_count", want.miss_count, out_miss_count);
          results_seen++;
          if (want.hit) hits_seen++;
          if (want.filled_empty) fills_seen++;
          if (want.evicted) evicts_seen++;
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

/* tb/tb.sv */
module tb;
  import acl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_BLOCKS  = 19;
  localparam int SAT_BLOCK   = 6;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [IN_ADDR_BITS-1:0] in_address;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_hit;
  logic [WAY_BITS-1:0]     out_way;
  logic                    out_filled_empty;
  logic                    out_evicted;
  logic [OUT_TAG_BITS-1:0] out_evicted_tag;
  logic [OUT_TAG_BITS-1:0] out_new_tag;
  logic [CNT_BITS-1:0]     out_hit_count;
  logic [CNT_BITS-1:0]     out_miss_count;

  int fail_count;
  int pending;
  int results_seen;
  int hits_seen;
  int fills_seen;
  int evicts_seen;
  int sent_count   = 0;
  int cycle_count  = 0;
  bit quiet        = 1'b0;

  logic [TAG_BITS-1:0] tag_pool [16];

  assoc_cache_lru_lookup u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_filled_empty (out_filled_empty),
    .out_evicted      (out_evicted),
    .out_evicted_tag  (out_evicted_tag),
    .out_new_tag      (out_new_tag),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count)
  );

  lru_lookup_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_filled_empty (out_filled_empty),
    .out_evicted      (out_evicted),
    .out_evicted_tag  (out_evicted_tag),
    .out_new_tag      (out_new_tag),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen),
    .hits_seen        (hits_seen),
    .fills_seen       (fills_seen),
    .evicts_seen      (evicts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL assoc_cache_lru_lookup");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [IN_ADDR_BITS-1:0] block_addr(input logic [TAG_BITS-1:0] tag);
    logic [IN_ADDR_BITS-1:0] a;
    a = IN_ADDR_BITS'(tag) << OFFSET_BITS;
    return a | IN_ADDR_BITS'($urandom_range(0, WORDS_PER_BLOCK - 1));
  endfunction

  task automatic send_req(input logic [IN_ADDR_BITS-1:0] addr);
    int gap;
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    sent_count++;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic stall_val;
    int   run;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 9) < 6) begin
        stall_val = 1'b0;
        run       = $urandom_range(1, 8);
      end else begin
        stall_val = 1'b1;
        run       = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      repeat (run) begin
        out_stall <= stall_val;
        @(posedge clk);
      end
    end
  end

  initial begin
    int                      set_size;
    int                      n_items;
    bit                      use_pool;
    logic [IN_ADDR_BITS-1:0] addr;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_address <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Fill all eight lines with extreme and alternating tags, hit a few, then force evictions.
    send_req(16'h0000);
    send_req(16'h0003);
    send_req(16'hFFFF);
    send_req(16'hFFFC);
    send_req(16'h5555);
    send_req(16'hAAAA);
    send_req(16'h1234);
    send_req(16'h8000);
    send_req(16'h7FFF);
    send_req(16'h4000);
    send_req(16'h0001);
    send_req(16'h0100);
    send_req(16'h0101);
    send_req(16'h2468);
    send_req(16'hFFFE);
    send_req(16'h0002);

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (blk == SAT_BLOCK || $urandom_range(0, 3) == 0) wait_drain();
      // The long block keeps two hot lines busy so every other age saturates and ties form.
      if (blk == SAT_BLOCK) begin
        set_size = 2;
        n_items  = 300;
      end else begin
        set_size = $urandom_range(1, 12);
        n_items  = 40;
      end
      for (int t = 0; t < set_size; t++) tag_pool[t] = TAG_BITS'($urandom);
      for (int k = 0; k < n_items; k++) begin
        use_pool = (blk == SAT_BLOCK) ? (k < 280) : ($urandom_range(0, 99) < 80);
        if (use_pool) addr = block_addr(tag_pool[$urandom_range(0, set_size - 1)]);
        else addr = IN_ADDR_BITS'($urandom);
        send_req(addr);
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests and checked %0d results.", sent_count, results_seen);
    $display("Results held %0d hits, %0d fills of free lines and %0d evictions.",
             hits_seen, fills_seen, evicts_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS assoc_cache_lru_lookup");
    end else begin
      $display("FAIL assoc_cache_lru_lookup");
    end
    $finish;
  end

endmodule

/* files.f */
src/acl_pkg.sv
src/acl_ctrl.sv
src/acl_dp.sv
src/assoc_cache_lru_lookup.sv
tb/lru_lookup_checker.sv
tb/tb.sv
